FILE: hw/rtl/cigar_parser_with_lengths_defines.svh
// ----------------------------------------------------------------------------
// CIGAR parser assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CIGAR_PARSER_WITH_LENGTHS_DEFINES_SVH
`define CIGAR_PARSER_WITH_LENGTHS_DEFINES_SVH

// A condition that must hold at every clock edge outside of reset.
`define CPL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition in one cycle that demands a consequence in the same cycle.
`define CPL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition in one cycle that demands a consequence in the next cycle.
`define CPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cpl_pkg.sv
// ----------------------------------------------------------------------------
// CIGAR parser package
// Types, character constants and error helpers shared by the parser files.
// ----------------------------------------------------------------------------
package cpl_pkg;

  localparam int unsigned LEN_BITS_DEF = 32;

  // Output queue geometry.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Characters of interest.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_EQUAL = 8'h3D;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_D     = 8'h44;

  localparam logic KIND_OP      = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_ZERO_LEN = 3'd1,
    ERR_BAD_CHAR = 3'd2,
    ERR_NO_OP    = 3'd3,
    ERR_UNSUP_OP = 3'd4,
    ERR_OVERFLOW = 3'd5
  } cpl_err_e;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  op_char;
    logic [31:0] op_length;
    logic [31:0] query_length;
    logic [31:0] target_length;
    cpl_err_e    error_code;
    logic        last_result;
  } cpl_rec_t;

  // Zero length, bad character and missing operation stop the parse.
  function automatic logic is_fatal(cpl_err_e e);
    return (e == ERR_ZERO_LEN) || (e == ERR_BAD_CHAR) || (e == ERR_NO_OP);
  endfunction

  // The first error sticks, except that a fatal one replaces a non-fatal one.
  function automatic cpl_err_e raise_err(cpl_err_e cur, cpl_err_e code);
    cpl_err_e res;
    res = cur;
    if ((cur == ERR_NONE) || (is_fatal(code) && !is_fatal(cur))) begin
      res = code;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/cpl_if.sv
// ----------------------------------------------------------------------------
// CIGAR parser channel interfaces
// Valid/ready channels for input characters and for result records.
// ----------------------------------------------------------------------------
interface cpl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface cpl_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [7:0]  op_char;
  logic [31:0] op_length;
  logic [31:0] query_length;
  logic [31:0] target_length;
  logic [2:0]  error_code;
  logic        last_result;

  modport source (
    output valid, output record_kind, output op_char, output op_length,
    output query_length, output target_length, output error_code,
    output last_result, input ready
  );
  modport sink (
    input valid, input record_kind, input op_char, input op_length,
    input query_length, input target_length, input error_code,
    input last_result, output ready
  );
endinterface

FILE: hw/rtl/cpl_step.sv
// ----------------------------------------------------------------------------
// CIGAR parser step logic
// Next parse state and the records produced by one character.
// ----------------------------------------------------------------------------
module cpl_step import cpl_pkg::*; #(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  logic [7:0]          char_i,
  input  logic                last_i,
  input  logic [LEN_BITS-1:0] acc_i,
  input  logic [LEN_BITS-1:0] qtot_i,
  input  logic [LEN_BITS-1:0] ttot_i,
  input  cpl_err_e            err_i,
  output logic [LEN_BITS-1:0] acc_o,
  output logic [LEN_BITS-1:0] qtot_o,
  output logic [LEN_BITS-1:0] ttot_o,
  output cpl_err_e            err_o,
  output logic [1:0]          push_n_o,
  output cpl_rec_t            rec_a_o,
  output cpl_rec_t            rec_b_o
);

  localparam logic [LEN_BITS-1:0] LenMax = '1;

  logic                is_digit;
  logic                is_op;
  logic [LEN_BITS+3:0] acc_x10;
  logic [LEN_BITS:0]   q_sum;
  logic [LEN_BITS:0]   t_sum;
  logic [LEN_BITS-1:0] acc_n;
  logic [LEN_BITS-1:0] q_n;
  logic [LEN_BITS-1:0] t_n;
  cpl_err_e            code;
  cpl_err_e            err_step;
  cpl_err_e            err_fin;
  logic                emit;
  logic                unsup;
  logic [LEN_BITS+31:0] acc_pad;
  logic [LEN_BITS+31:0] q_pad;
  logic [LEN_BITS+31:0] t_pad;
  cpl_rec_t            op_rec;
  cpl_rec_t            sum_rec;

  assign is_digit = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
  assign is_op    = ((char_i >= CHAR_UC_A) && (char_i <= CHAR_UC_Z)) ||
                    (char_i == CHAR_EQUAL);

  // Times ten as two shifted copies, plus the digit; the top nibble flags overflow.
  assign acc_x10 = ({4'b0, acc_i} << 3) + ({4'b0, acc_i} << 1) +
                   (LEN_BITS + 4)'(char_i[3:0]);
  assign q_sum   = {1'b0, qtot_i} + {1'b0, acc_i};
  assign t_sum   = {1'b0, ttot_i} + {1'b0, acc_i};

  always_comb begin
    acc_n = acc_i;
    q_n   = qtot_i;
    t_n   = ttot_i;
    code  = ERR_NONE;
    emit  = 1'b0;
    unsup = 1'b0;
    if (!is_fatal(err_i)) begin
      if (is_digit) begin
        if (acc_x10[LEN_BITS+3:LEN_BITS] != 4'd0) begin
          acc_n = LenMax;
          code  = ERR_OVERFLOW;
        end else begin
          acc_n = acc_x10[LEN_BITS-1:0];
        end
      end else if (is_op) begin
        if (acc_i == '0) begin
          code = ERR_ZERO_LEN;
        end else begin
          emit  = 1'b1;
          acc_n = '0;
          if ((char_i == CHAR_M) || (char_i == CHAR_I)) begin
            q_n = q_sum[LEN_BITS] ? LenMax : q_sum[LEN_BITS-1:0];
            if (q_sum[LEN_BITS]) begin
              code = ERR_OVERFLOW;
            end
          end
          if ((char_i == CHAR_M) || (char_i == CHAR_D)) begin
            t_n = t_sum[LEN_BITS] ? LenMax : t_sum[LEN_BITS-1:0];
            if (t_sum[LEN_BITS]) begin
              code = ERR_OVERFLOW;
            end
          end
          if ((char_i != CHAR_M) && (char_i != CHAR_I) && (char_i != CHAR_D)) begin
            unsup = 1'b1;
            code  = ERR_UNSUP_OP;
          end
        end
      end else begin
        code = ERR_BAD_CHAR;
      end
    end
  end

  assign err_step = raise_err(err_i, code);

  // An open run at the end of the string means the operation letter is missing.
  always_comb begin
    err_fin = err_step;
    if (last_i && !is_fatal(err_step) && (acc_n != '0)) begin
      err_fin = raise_err(err_step, ERR_NO_OP);
    end
  end

  assign acc_pad = {32'd0, acc_i};
  assign q_pad   = {32'd0, q_n};
  assign t_pad   = {32'd0, t_n};

  always_comb begin
    op_rec               = '0;
    op_rec.record_kind   = KIND_OP;
    op_rec.op_char       = char_i;
    op_rec.op_length     = acc_pad[31:0];
    op_rec.error_code    = unsup ? ERR_UNSUP_OP : ERR_NONE;
    op_rec.last_result   = 1'b0;

    sum_rec               = '0;
    sum_rec.record_kind   = KIND_SUMMARY;
    sum_rec.query_length  = q_pad[31:0];
    sum_rec.target_length = t_pad[31:0];
    sum_rec.error_code    = err_fin;
    sum_rec.last_result   = 1'b1;
  end

  assign rec_a_o  = emit ? op_rec : sum_rec;
  assign rec_b_o  = sum_rec;
  assign push_n_o = {1'b0, emit} + {1'b0, last_i};

  // The string ends: everything returns to its reset value.
  assign acc_o  = last_i ? '0 : acc_n;
  assign qtot_o = last_i ? '0 : q_n;
  assign ttot_o = last_i ? '0 : t_n;
  assign err_o  = last_i ? ERR_NONE : err_step;

endmodule

FILE: hw/rtl/cpl_out_fifo.sv
// ----------------------------------------------------------------------------
// CIGAR parser output queue
// Small register queue that takes up to two records per cycle and sends at most one.
// ----------------------------------------------------------------------------
module cpl_out_fifo import cpl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_n_i,
  input  cpl_rec_t         rec_a_i,
  input  cpl_rec_t         rec_b_i,
  output logic             room_o,
  cpl_out_if.source        out_o
);

  cpl_rec_t               mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OUT_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0]   cnt_q, cnt_d;
  logic [OUT_PTR_W-1:0]   wr_ptr_nx;
  logic                   pop;
  cpl_rec_t               head;

  assign pop       = out_o.valid && out_o.ready;
  assign wr_ptr_nx = wr_ptr_q + OUT_PTR_W'(1);
  assign wr_ptr_d  = wr_ptr_q + OUT_PTR_W'(push_n_i);
  assign rd_ptr_d  = rd_ptr_q + OUT_PTR_W'(pop);
  assign cnt_d     = cnt_q + OUT_CNT_W'(push_n_i) - OUT_CNT_W'(pop);

  // Room for the worst case of one character: an op record and a summary.
  assign room_o = cnt_q <= OUT_CNT_W'(OUT_DEPTH - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= rec_a_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= rec_b_i;
    end
  end

  assign head                = mem_q[rd_ptr_q];
  assign out_o.valid         = cnt_q != '0;
  assign out_o.record_kind   = head.record_kind;
  assign out_o.op_char       = head.op_char;
  assign out_o.op_length     = head.op_length;
  assign out_o.query_length  = head.query_length;
  assign out_o.target_length = head.target_length;
  assign out_o.error_code    = head.error_code;
  assign out_o.last_result   = head.last_result;

endmodule

FILE: hw/rtl/cigar_parser_with_lengths.sv
// ----------------------------------------------------------------------------
// CIGAR string parser with query and target lengths
// Parses a CIGAR string one character per beat into op and summary records.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per input beat, with last_char marking
// the end of a string. Digits build a run length; an upper-case letter or '='
// closes the run and produces an operation record. M adds the run to both
// the query and the target total, I to the query total and D to the target
// total; any other letter is passed on with an unsupported-op code and left
// out of the totals. The final character also produces a summary record with
// both totals and the sticky error code, and the parser then starts clean for
// the next string. A zero run, a character outside digits, capitals and '=',
// or a run left open at the end is fatal: the rest of the string is skipped
// up to the summary. Runs and totals saturate at all ones on LEN_BITS bits
// and flag an overflow; the outputs carry the low 32 bits.
// Throughput is one character per clock cycle while the input does not stall.
// A character is first taken into an input register, then handled by the
// combinational step logic (a times-ten accumulate and two saturating adds),
// which writes its records into a four-entry output queue. The input register
// moves on only when the queue has two free entries, so the input stalls while
// three or more records are waiting. With the output side ready in every cycle
// no more than two records ever wait and the input never stalls; a slow output
// side sets the pace then. The records of a character pass through the input
// register and the output queue before they can be taken at the output.
// ----------------------------------------------------------------------------
`include "cigar_parser_with_lengths_defines.svh"

module cigar_parser_with_lengths import cpl_pkg::*; #(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpl_in_if.sink    in_i,
  cpl_out_if.source out_o
);

  // Input register stage.
  logic                s_valid_q;
  logic [7:0]          s_char_q;
  logic                s_last_q;

  // Parse state, carried from one character to the next.
  logic [LEN_BITS-1:0] acc_q, acc_d;
  logic [LEN_BITS-1:0] qtot_q, qtot_d;
  logic [LEN_BITS-1:0] ttot_q, ttot_d;
  cpl_err_e            err_q, err_d;

  logic                room;
  logic                fire;
  logic                in_take;
  logic [1:0]          push_n;
  logic [1:0]          push_gated;
  cpl_rec_t            rec_a;
  cpl_rec_t            rec_b;

  // Conditions watched by the assertions.
  logic                parse_idle;
  logic                fatal_held;

  // The held character is processed once the queue can take its records.
  assign fire       = s_valid_q && room;
  assign in_i.ready = !s_valid_q || fire;
  assign in_take    = in_i.valid && in_i.ready;
  assign push_gated = fire ? push_n : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s_char_q <= in_i.char_code;
      s_last_q <= in_i.last_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      qtot_q <= '0;
      ttot_q <= '0;
      err_q  <= ERR_NONE;
    end else if (fire) begin
      acc_q  <= acc_d;
      qtot_q <= qtot_d;
      ttot_q <= ttot_d;
      err_q  <= err_d;
    end
  end

  cpl_step #(
    .LEN_BITS (LEN_BITS)
  ) u_step (
    .char_i   (s_char_q),
    .last_i   (s_last_q),
    .acc_i    (acc_q),
    .qtot_i   (qtot_q),
    .ttot_i   (ttot_q),
    .err_i    (err_q),
    .acc_o    (acc_d),
    .qtot_o   (qtot_d),
    .ttot_o   (ttot_d),
    .err_o    (err_d),
    .push_n_o (push_n),
    .rec_a_o  (rec_a),
    .rec_b_o  (rec_b)
  );

  cpl_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_gated),
    .rec_a_i  (rec_a),
    .rec_b_i  (rec_b),
    .room_o   (room),
    .out_o    (out_o)
  );

  assign parse_idle = (acc_q == '0) && (qtot_q == '0) && (ttot_q == '0) &&
                      (err_q == ERR_NONE);
  assign fatal_held = fire && is_fatal(err_q) && !s_last_q;

  // The end of a string leaves the parser in its reset state.
  `CPL_ASSERT_NEXT(a_clean_after_last, fire && s_last_q, parse_idle, "state not cleared")

  // After a fatal error nothing but the final summary is produced.
  `CPL_ASSERT_IMPL(a_fatal_silent, fatal_held, push_n == 2'd0, "record after fatal error")

  // Every processed character that produces a record makes output valid.
  `CPL_ASSERT_NEXT(a_push_shows, fire && (push_n != 2'd0), out_o.valid, "record not offered")

endmodule

FILE: test/cigar_parser_with_lengths_checker.sv
// ----------------------------------------------------------------------------
// CIGAR parser record checker
// Watches the character and record channels, predicts the records of every
// accepted character and compares each record beat with the oldest one owed.
// ----------------------------------------------------------------------------
module cigar_parser_with_lengths_checker import cpl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpl_in_if           chars_i,
  cpl_out_if          records_i,
  output int unsigned mismatches_o,
  output int unsigned owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Runs and totals saturate here for a 32-bit length.
  localparam longint unsigned LEN_CAP = 64'h0000_0000_FFFF_FFFF;

  longint unsigned run_len    = 0;
  longint unsigned query_sum  = 0;
  longint unsigned target_sum = 0;
  cpl_err_e        string_err = ERR_NONE;
  cpl_rec_t        owed_records[$];
  int unsigned     mismatch_count = 0;
  int unsigned     owed_count     = 0;

  assign mismatches_o = mismatch_count;
  assign owed_o       = owed_count;

  // Codes below the unsupported-op code, other than none, end the parse.
  function automatic bit stops_parse(cpl_err_e code);
    return (code != ERR_NONE) && (code < ERR_UNSUP_OP);
  endfunction

  function automatic void flag_error(cpl_err_e code);
    if (string_err == ERR_NONE) begin
      string_err = code;
    end else if (stops_parse(code) && !stops_parse(string_err)) begin
      string_err = code;
    end
  endfunction

  function automatic longint unsigned capped_sum(longint unsigned a, longint unsigned b);
    if (a + b > LEN_CAP) begin
      flag_error(ERR_OVERFLOW);
      return LEN_CAP;
    end
    return a + b;
  endfunction

  function automatic void predict_char(logic [7:0] code, logic final_char);
    cpl_rec_t rec;
    longint unsigned digit;
    if (!stops_parse(string_err)) begin
      if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
        digit = longint'(code - CHAR_ZERO);
        if (run_len * 10 + digit > LEN_CAP) begin
          run_len = LEN_CAP;
          flag_error(ERR_OVERFLOW);
        end else begin
          run_len = run_len * 10 + digit;
        end
      end else if ((code >= CHAR_UC_A && code <= CHAR_UC_Z) || code == CHAR_EQUAL) begin
        if (run_len == 0) begin
          flag_error(ERR_ZERO_LEN);
        end else begin
          rec             = '0;
          rec.record_kind = KIND_OP;
          rec.op_char     = code;
          rec.op_length   = run_len[31:0];
          rec.error_code  = ERR_NONE;
          case (code)
            CHAR_M: begin
              query_sum  = capped_sum(query_sum, run_len);
              target_sum = capped_sum(target_sum, run_len);
            end
            CHAR_I: begin
              query_sum = capped_sum(query_sum, run_len);
            end
            CHAR_D: begin
              target_sum = capped_sum(target_sum, run_len);
            end
            default: begin
              rec.error_code = ERR_UNSUP_OP;
              flag_error(ERR_UNSUP_OP);
            end
          endcase
          owed_records = {owed_records, rec};
          run_len = 0;
        end
      end else begin
        flag_error(ERR_BAD_CHAR);
      end
    end

    if (final_char) begin
      if (!stops_parse(string_err) && run_len != 0) begin
        flag_error(ERR_NO_OP);
      end
      rec               = '0;
      rec.record_kind   = KIND_SUMMARY;
      rec.query_length  = query_sum[31:0];
      rec.target_length = target_sum[31:0];
      rec.error_code    = string_err;
      rec.last_result   = 1'b1;
      owed_records = {owed_records, rec};
      run_len    = 0;
      query_sum  = 0;
      target_sum = 0;
      string_err = ERR_NONE;
    end
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cpl_rec_t want;
    if (!rst_ni) begin
      owed_records.delete();
      run_len    = 0;
      query_sum  = 0;
      target_sum = 0;
      string_err = ERR_NONE;
      owed_count <= 0;
    end else begin
      // A record beat at this edge always stems from an earlier character,
      // so it is checked before this edge's character is predicted.
      if (records_i.valid === 1'b1 && records_i.ready === 1'b1) begin
        if (owed_records.size() == 0) begin
          $error("record beat with no record owed: kind %0h op %0h",
                 records_i.record_kind, records_i.op_char);
          mismatch_count++;
        end else begin
          want = owed_records.pop_front();
          check_field("record_kind", 32'(want.record_kind), 32'(records_i.record_kind));
          check_field("op_char", 32'(want.op_char), 32'(records_i.op_char));
          check_field("op_length", want.op_length, records_i.op_length);
          check_field("query_length", want.query_length, records_i.query_length);
          check_field("target_length", want.target_length, records_i.target_length);
          check_field("error_code", 32'(want.error_code), 32'(records_i.error_code));
          check_field("last_result", 32'(want.last_result), 32'(records_i.last_result));
        end
      end
      if (chars_i.valid === 1'b1 && chars_i.ready === 1'b1) begin
        predict_char(chars_i.char_code, chars_i.last_char);
      end
      owed_count <= owed_records.size();
    end
  end

endmodule

FILE: test/cigar_parser_with_lengths_tb.sv
// ----------------------------------------------------------------------------
// CIGAR parser testbench
// Feeds directed and random CIGAR strings under varying flow control and
// takes the verdict from the record checker that sits beside the parser.
// ----------------------------------------------------------------------------
module cigar_parser_with_lengths_tb import cpl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Roughly this many characters are sent in each of the three phases.
  localparam int unsigned CHARS_PER_PHASE = 200;
  // Length of a receiver hold-off, long enough to fill the parser completely.
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  // Cycles to let pass once nothing is owed; covers the input register,
  // the step logic and the output queue with margin.
  localparam int unsigned SETTLE_CYCLES = 8;
  // A run still going at this cycle count is ended as a hang.
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cpl_in_if  char_bus ();
  cpl_out_if rec_bus ();

  int unsigned mismatches;
  int unsigned owed_records;

  // Flow control knobs. The sender gap chance is only used by the stimulus
  // process; the receiver knobs are handed over with nonblocking writes.
  int unsigned src_idle_pct      = 0;
  int unsigned sink_idle_pct     = 0;
  int unsigned hold_req_count    = 0;
  int unsigned chars_sent        = 0;
  int unsigned cycle_count       = 0;

  // Characters of the string being built, sent as one string.
  logic [7:0] pending_chars[$];

  cigar_parser_with_lengths dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_bus),
    .out_o  (rec_bus)
  );

  cigar_parser_with_lengths_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chars_i      (char_bus),
    .records_i    (rec_bus),
    .mismatches_o (mismatches),
    .owed_o       (owed_records)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Guard against a hang: a parser that stops handing out records or stops
  // taking characters ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver side. Each new hold request makes it drop ready for a long
  // stretch that it counts itself; otherwise ready follows the idle chance
  // of the current phase.
  initial begin : record_sink
    int unsigned hold_left;
    int unsigned hold_grant;
    hold_left  = 0;
    hold_grant = 0;
    rec_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        rec_bus.ready <= 1'b0;
        hold_left--;
      end else if (hold_grant != hold_req_count) begin
        hold_grant++;
        hold_left = LONG_HOLD_CYCLES - 1;
        rec_bus.ready <= 1'b0;
      end else begin
        rec_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Offers one character beat, after a random gap, and waits for it to be
  // taken. The valid line is only ever written once per clock edge: either
  // lowered for a gap or raised for the next beat.
  task automatic send_char(input logic [7:0] code, input logic final_char);
    while ($urandom_range(99) < src_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= code;
    char_bus.last_char <= final_char;
    do @(posedge clk_i); while (char_bus.ready !== 1'b1);
    chars_sent++;
  endtask

  // Sends the built string with the end flag on its final character.
  task automatic send_string();
    for (int i = 0; i < pending_chars.size(); i++) begin
      send_char(pending_chars[i], i == pending_chars.size() - 1);
    end
    pending_chars.delete();
  endtask

  // Appends one character to the string being built.
  function automatic void add_char(logic [7:0] code);
    pending_chars = {pending_chars, code};
  endfunction

  function automatic void add_text(string text);
    for (int i = 0; i < text.len(); i++) begin
      add_char(text[i]);
    end
  endfunction

  function automatic void add_number(longint unsigned value);
    add_text($sformatf("%0d", value));
  endfunction

  // A run length: mostly short, sometimes with a leading zero, sometimes a
  // full 32-bit value and sometimes ten to twelve digits that may pass 32 bits.
  function automatic void add_run_length();
    int unsigned pick;
    int unsigned digits;
    pick = $urandom_range(99);
    if (pick < 78) begin
      add_number($urandom_range(1, 999));
    end else if (pick < 86) begin
      add_char(CHAR_ZERO);
      add_number($urandom_range(1, 99));
    end else if (pick < 94) begin
      add_number($urandom());
    end else begin
      digits = $urandom_range(10, 12);
      add_char(8'(CHAR_ZERO + $urandom_range(1, 9)));
      for (int i = 1; i < digits; i++) begin
        add_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
    end
  endfunction

  // Mostly the three counted operations, now and then another capital or '='.
  function automatic void add_op_letter();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      add_char(CHAR_M);
    end else if (pick < 57) begin
      add_char(CHAR_I);
    end else if (pick < 84) begin
      add_char(CHAR_D);
    end else if (pick < 90) begin
      add_char(CHAR_EQUAL);
    end else begin
      add_char(8'(CHAR_UC_A + $urandom_range(0, 25)));
    end
  endfunction

  // Builds and sends one random string. Most strings are well formed so that
  // the totals and the overflow paths get exercised; the rest are strings
  // that break off in a run, hit a zero run, or are plain noise.
  task automatic send_random_string();
    int unsigned shape;
    int unsigned n_ops;
    int unsigned pick;
    shape = $urandom_range(99);
    if (shape < 66) begin
      n_ops = $urandom_range(1, 6);
      repeat (n_ops) begin
        add_run_length();
        add_op_letter();
      end
    end else if (shape < 74) begin
      // Large runs on counted operations can push the totals to saturation.
      n_ops = $urandom_range(2, 4);
      repeat (n_ops) begin
        add_number($urandom_range(32'h8000_0000, 32'hFFFF_FFFF));
        pick = $urandom_range(2);
        add_char(pick == 0 ? CHAR_M : (pick == 1 ? CHAR_I : CHAR_D));
      end
    end else if (shape < 82) begin
      // The string ends in the middle of a run.
      repeat ($urandom_range(0, 3)) begin
        add_run_length();
        add_op_letter();
      end
      add_run_length();
    end else if (shape < 90) begin
      // A zero run somewhere; whatever follows is skipped by the parser.
      repeat ($urandom_range(0, 2)) begin
        add_run_length();
        add_op_letter();
      end
      add_char(CHAR_ZERO);
      add_op_letter();
      repeat ($urandom_range(0, 2)) begin
        add_run_length();
        add_op_letter();
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          add_char(8'($urandom_range(255)));
        end else if (pick < 60) begin
          add_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
        end else if (pick < 80) begin
          add_char(8'(CHAR_UC_A + $urandom_range(0, 25)));
        end else if (pick < 90) begin
          add_char(8'(8'h61 + $urandom_range(0, 25)));
        end else begin
          add_char(CHAR_EQUAL);
        end
      end
    end
    send_string();
  endtask

  // Stops offering beats until every owed record has come out, then lets
  // the parser settle. The owed count from the checker is updated at the
  // edge that accepts a beat, so it is read from the next edge on.
  task automatic pause_until_drained();
    char_bus.valid <= 1'b0;
    do @(posedge clk_i); while (owed_records != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : char_source
    int unsigned src_pct_by_phase[3];
    int unsigned sink_pct_by_phase[3];
    src_pct_by_phase  = '{34, 86, 0};
    sink_pct_by_phase = '{86, 34, 0};

    char_bus.valid     = 1'b0;
    char_bus.char_code = 8'h00;
    char_bus.last_char = 1'b0;
    rst_ni             = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct   = src_pct_by_phase[phase];
      sink_idle_pct <= sink_pct_by_phase[phase];
      // In the later phases the receiver stops for a long stretch right
      // away while characters keep coming, so the output queue and then
      // the input register fill up and the parser must stall its input.
      if (phase > 0) begin
        hold_req_count <= hold_req_count + 1;
      end

      if (phase == 0) begin
        // Counted operations, with the final character closing an op, so
        // that one beat yields both an op record and the summary.
        add_text("9M2I3D");
        send_string();
        // A zero run is fatal and gives no op record.
        add_text("0M");
        send_string();
        // '=' is passed on but flagged as unsupported.
        add_text("5=");
        send_string();
        // Digits left open at the end of the string.
        add_text("7");
        send_string();
        // Top character code: invalid.
        add_char(8'hFF);
        send_string();
        // A NUL in the middle is invalid and the rest is skipped.
        add_text("3");
        add_char(8'h00);
        add_text("M");
        send_string();
        // A run that passes 32 bits saturates, on an unsupported op.
        add_text("9999999999X");
        send_string();
      end

      while (chars_sent < (phase + 1) * CHARS_PER_PHASE) begin
        send_random_string();
      end
      pause_until_drained();
    end

    if (mismatches == 0 && owed_records == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
